[hw/rtl/som_best_matching_unit_sparse_defines.svh]
// Assertion macros used by the best-matching-unit search top level
`ifndef SOM_BEST_MATCHING_UNIT_SPARSE_DEFINES_SVH
`define SOM_BEST_MATCHING_UNIT_SPARSE_DEFINES_SVH

// Check that cons holds in the same cycle as ante
`define SBMU_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sbmu: same-cycle check failed");

// Check that cons holds in the cycle after ante
`define SBMU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sbmu: next-cycle check failed");

`endif

[hw/rtl/sbmu_pkg.sv]
// Types and constants of the best-matching-unit search
`timescale 1ns / 1ps
package sbmu_pkg;

   localparam int NODE_IDX_BITS = 8;
   localparam int DIM_BITS      = 6;
   localparam int VALUE_BITS    = 16;
   localparam int PROD_BITS     = 2 * VALUE_BITS;
   localparam int NORM_BITS     = 37;
   localparam int ACC_BITS      = 38;
   localparam int DIST_BITS     = 39;
   localparam int COORD_BITS    = 4;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 7;

   localparam logic [CSR_IDX_BITS-1:0] CSR_MAP_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAP_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DIMENSIONS = 2'd2;

   localparam logic FUNC_WEIGHT  = 1'b0;
   localparam logic FUNC_FEATURE = 1'b1;

   typedef struct packed {
      logic                         func;
      logic [NODE_IDX_BITS-1:0]     node_index;
      logic [DIM_BITS-1:0]          dim_index;
      logic signed [VALUE_BITS-1:0] value;
      logic [NORM_BITS-1:0]         vector_norm;
      logic                         last_element;
   } req_word_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] bmu_x;
      logic [COORD_BITS-1:0] bmu_y;
      logic [DIST_BITS-1:0]  best_distance;
   } rsp_word_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } chain_ctl_type;

endpackage

[hw/rtl/sbmu_cell.sv]
// One accumulator cell of the rotating dot-product chain
`timescale 1ns / 1ps
module sbmu_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  sbmu_pkg::chain_ctl_type             ctl,
   input  logic signed [sbmu_pkg::ACC_BITS-1:0] d_in,
   output logic signed [sbmu_pkg::ACC_BITS-1:0] q
);
   import sbmu_pkg::*;

   logic signed [ACC_BITS-1:0] acc_ff;

   // Clear, take the neighbour's word, or hold
   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         acc_ff <= '0;
      end else if (ctl.shift) begin
         acc_ff <= d_in;
      end
   end

   assign q = acc_ff;

endmodule

[hw/rtl/sbmu_chain.sv]
// Ring of accumulator cells with a saturating adder at the head
`timescale 1ns / 1ps
module sbmu_chain #(
   parameter int CELLS = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sbmu_pkg::chain_ctl_type              ctl,
   input  logic signed [sbmu_pkg::PROD_BITS-1:0] addend,
   output logic signed [sbmu_pkg::ACC_BITS-1:0]  head
);
   import sbmu_pkg::*;

   localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
   localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

   logic signed [ACC_BITS-1:0] q [CELLS];
   logic signed [ACC_BITS:0]   sum;
   logic signed [ACC_BITS-1:0] tail_in;

   // Add the product to the head word and saturate to the accumulator range
   always_comb begin
      sum = $signed({head[ACC_BITS-1], head})
          + $signed({{(ACC_BITS+1-PROD_BITS){addend[PROD_BITS-1]}}, addend});
      if (sum[ACC_BITS] != sum[ACC_BITS-1]) begin
         tail_in = sum[ACC_BITS] ? ACC_MIN : ACC_MAX;
      end else begin
         tail_in = sum[ACC_BITS-1:0];
      end
   end

   assign head = q[0];

   // Each cell takes its right neighbour; the last takes the updated head
   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      if (i == CELLS - 1) begin : g_tail
         sbmu_cell u_cell (
            .clock (clock),
            .reset (reset),
            .ctl   (ctl),
            .d_in  (tail_in),
            .q     (q[i])
         );
      end else begin : g_body
         sbmu_cell u_cell (
            .clock (clock),
            .reset (reset),
            .ctl   (ctl),
            .d_in  (q[i+1]),
            .q     (q[i])
         );
      end
   end

endmodule

[hw/rtl/som_best_matching_unit_sparse.sv]
// Top level of the sparse best-matching-unit search
//
//   channel  ports                         direction  flow control
//   request  start, busy, req_word         in         start taken when busy low
//   result   rsp_valid, rsp_word           out        one-cycle strobe, no stall
//   config   csr_we, csr_index, csr_wdata  in         write taken when csr_we high
//
// A weight write reads the old weight and norm, squares them and writes back.
// For a feature element the dot-product words rotate once around the cell ring,
// one node per cycle through one multiplier. The last element adds a second
// rotation of the same length to form distances and track the minimum; the
// result strobe follows it and the ring is cleared. After reset a clearing pass
// zeroes the weight and norm memories; busy stays high for it. The receiver
// cannot stall.
`timescale 1ns / 1ps
`include "som_best_matching_unit_sparse_defines.svh"
module som_best_matching_unit_sparse #(
   parameter int MAX_MAP_X = 16,
   parameter int MAX_MAP_Y = 16,
   parameter int MAX_DIMS  = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  sbmu_pkg::req_word_type               req_word,
   output logic                                 rsp_valid,
   output sbmu_pkg::rsp_word_type               rsp_word,
   input  logic                                 csr_we,
   input  logic [sbmu_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [sbmu_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import sbmu_pkg::*;

   localparam int NODES = MAX_MAP_X * MAX_MAP_Y;
   localparam int WORDS = NODES * MAX_DIMS;
   localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int NIW   = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int NW    = $clog2(NODES + 1);
   localparam int CW    = $clog2(NODES + 2);
   localparam int XW    = $clog2(MAX_MAP_X + 1);
   localparam int YW    = $clog2(MAX_MAP_Y + 1);
   localparam int DW    = $clog2(MAX_DIMS + 1);
   localparam int W_RESET = (16 > MAX_MAP_X) ? MAX_MAP_X : 16;
   localparam int H_RESET = (16 > MAX_MAP_Y) ? MAX_MAP_Y : 16;
   localparam int D_RESET = (64 > MAX_DIMS) ? MAX_DIMS : 64;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_WR1   = 3'd2;
   localparam logic [2:0] S_WR2   = 3'd3;
   localparam logic [2:0] S_MAC   = 3'd4;
   localparam logic [2:0] S_BMU   = 3'd5;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] clr_ff, clr_in;

   logic [XW-1:0] w_eff_ff;
   logic [YW-1:0] h_eff_ff;
   logic [DW-1:0] d_eff_ff;
   logic [NW-1:0] area;

   logic [DIM_BITS-1:0]          dim_ff;
   logic [NODE_IDX_BITS-1:0]     node_ff;
   logic signed [VALUE_BITS-1:0] value_ff;
   logic [NORM_BITS-1:0]         vnorm_ff;
   logic                         last_ff;
   logic [AW-1:0]                waddr_ff;
   logic [AW-1:0]                req_addr;
   logic                         accept;
   logic                         wr_ok;

   logic signed [VALUE_BITS-1:0] weight_mem [WORDS];
   logic [NORM_BITS-1:0]         norm_mem [NODES];
   logic                         w_we, n_we;
   logic [AW-1:0]                w_wa, w_ra;
   logic signed [VALUE_BITS-1:0] w_wd;
   logic [NIW-1:0]               n_wa, n_ra;
   logic [NORM_BITS-1:0]         n_wd;
   logic signed [VALUE_BITS-1:0] w_rd_ff;
   logic [NORM_BITS-1:0]         n_rd_ff;

   logic signed [PROD_BITS-1:0] sq_new_ff, sq_old_ff, prod_ff;
   logic [NORM_BITS-1:0]        norm_new;

   chain_ctl_type               ctl;
   logic signed [PROD_BITS-1:0] addend;
   logic signed [ACC_BITS-1:0]  head;

   logic [CW-1:0]          head_idx;
   logic signed [40:0]     dist_full;
   logic [DIST_BITS-1:0]   dist_in, dist_ff;
   logic                   dvalid_in, dvalid_ff;
   logic [XW-1:0]          cx_ff, dx_ff, bx_ff, bx_next;
   logic [YW-1:0]          cy_ff, dy_ff, by_ff, by_next;
   logic [DIST_BITS-1:0]   best_ff, best_next;
   logic                   have_ff, take, finish;

   logic         rsp_valid_ff;
   rsp_word_type rsp_word_ff;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;
   assign area   = NW'(w_eff_ff) * NW'(h_eff_ff);

   assign req_addr = AW'(req_word.node_index) * AW'(MAX_DIMS) + AW'(req_word.dim_index);
   assign wr_ok    = (req_word.node_index < area) && (req_word.dim_index < d_eff_ff);

   // Configuration: store the clamped register values
   always_ff @(posedge clock) begin
      if (reset) begin
         w_eff_ff <= XW'(W_RESET);
         h_eff_ff <= YW'(H_RESET);
         d_eff_ff <= DW'(D_RESET);
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAP_WIDTH: begin
               if (csr_wdata[4:0] == 5'd0) w_eff_ff <= XW'(1);
               else if (csr_wdata[4:0] > MAX_MAP_X) w_eff_ff <= XW'(MAX_MAP_X);
               else w_eff_ff <= XW'(csr_wdata[4:0]);
            end
            CSR_MAP_HEIGHT: begin
               if (csr_wdata[4:0] == 5'd0) h_eff_ff <= YW'(1);
               else if (csr_wdata[4:0] > MAX_MAP_Y) h_eff_ff <= YW'(MAX_MAP_Y);
               else h_eff_ff <= YW'(csr_wdata[4:0]);
            end
            CSR_DIMENSIONS: begin
               if (csr_wdata == 7'd0) d_eff_ff <= DW'(1);
               else if (csr_wdata > MAX_DIMS) d_eff_ff <= DW'(MAX_DIMS);
               else d_eff_ff <= DW'(csr_wdata);
            end
            default: begin
               w_eff_ff <= w_eff_ff;
            end
         endcase
      end
   end

   // Sequencer: clearing pass, weight write, ring rotations
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      clr_in    = clr_ff;
      w_we      = 1'b0;
      w_wa      = waddr_ff;
      w_wd      = value_ff;
      w_ra      = waddr_ff;
      n_we      = 1'b0;
      n_wa      = NIW'(node_ff);
      n_wd      = norm_new;
      n_ra      = NIW'(node_ff);
      ctl.shift = 1'b0;
      ctl.clear = 1'b0;
      addend    = '0;
      finish    = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            w_we = 1'b1;
            w_wa = clr_ff;
            w_wd = '0;
            n_we = (clr_ff < NODES);
            n_wa = NIW'(clr_ff);
            n_wd = '0;
            if (clr_ff == AW'(WORDS - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + AW'(1);
            end
         end
         S_IDLE: begin
            w_ra   = req_addr;
            n_ra   = NIW'(req_word.node_index);
            cnt_in = '0;
            if (start) begin
               if (req_word.func == FUNC_WEIGHT) begin
                  if (wr_ok) state_in = S_WR1;
               end else if (req_word.dim_index < d_eff_ff) begin
                  state_in = S_MAC;
               end else if (req_word.last_element) begin
                  state_in = S_BMU;
               end
            end
         end
         S_WR1: begin
            state_in = S_WR2;
         end
         S_WR2: begin
            w_we     = 1'b1;
            n_we     = 1'b1;
            state_in = S_IDLE;
         end
         S_MAC: begin
            w_ra      = AW'(cnt_ff) * AW'(MAX_DIMS) + AW'(dim_ff);
            ctl.shift = (cnt_ff >= CW'(2));
            addend    = prod_ff;
            if (cnt_ff == CW'(NODES + 1)) begin
               state_in = last_ff ? S_BMU : S_IDLE;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         S_BMU: begin
            n_ra      = NIW'(cnt_ff);
            ctl.shift = (cnt_ff >= CW'(1)) && (cnt_ff <= CW'(NODES));
            if (cnt_ff == CW'(NODES + 1)) begin
               finish    = 1'b1;
               ctl.clear = 1'b1;
               state_in  = S_IDLE;
               cnt_in    = '0;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff   <= '0;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         clr_ff   <= clr_in;
      end
   end

   // Hold the accepted word
   always_ff @(posedge clock) begin
      if (accept) begin
         dim_ff   <= req_word.dim_index;
         node_ff  <= req_word.node_index;
         value_ff <= req_word.value;
         vnorm_ff <= req_word.vector_norm;
         last_ff  <= req_word.last_element;
         waddr_ff <= req_addr;
      end
   end

   // Weight and norm memories with registered reads
   always_ff @(posedge clock) begin
      if (w_we) weight_mem[w_wa] <= w_wd;
      w_rd_ff <= weight_mem[w_ra];
   end

   always_ff @(posedge clock) begin
      if (n_we) norm_mem[n_wa] <= n_wd;
      n_rd_ff <= norm_mem[n_ra];
   end

   // Squares for the norm correction and the product for the ring
   always_ff @(posedge clock) begin
      sq_new_ff <= value_ff * value_ff;
      sq_old_ff <= w_rd_ff * w_rd_ff;
      prod_ff   <= value_ff * w_rd_ff;
   end

   assign norm_new = n_rd_ff + NORM_BITS'($unsigned(sq_new_ff))
                   - NORM_BITS'($unsigned(sq_old_ff));

   sbmu_chain #(
      .CELLS (NODES)
   ) u_chain (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .addend (addend),
      .head   (head)
   );

   // Distance of the node at the ring head, clamped at zero
   assign head_idx  = cnt_ff - CW'(1);
   assign dist_full = $signed({4'b0, vnorm_ff}) + $signed({4'b0, n_rd_ff})
                    - $signed({{2{head[ACC_BITS-1]}}, head, 1'b0});
   assign dist_in   = dist_full[40] ? '0 : dist_full[DIST_BITS-1:0];
   assign dvalid_in = (state_ff == S_BMU) && ctl.shift && (head_idx < area);

   always_ff @(posedge clock) begin
      dist_ff <= dist_in;
      dx_ff   <= cx_ff;
      dy_ff   <= cy_ff;
   end

   // Advance the node coordinates in row-major order
   always_ff @(posedge clock) begin
      if (reset || state_ff != S_BMU) begin
         cx_ff <= '0;
         cy_ff <= '0;
      end else if (ctl.shift) begin
         if (cx_ff == XW'(w_eff_ff - XW'(1))) begin
            cx_ff <= '0;
            cy_ff <= cy_ff + YW'(1);
         end else begin
            cx_ff <= cx_ff + XW'(1);
         end
      end
   end

   // Keep the first strictly smaller distance
   assign take      = dvalid_ff && (!have_ff || (dist_ff < best_ff));
   assign best_next = take ? dist_ff : best_ff;
   assign bx_next   = take ? dx_ff : bx_ff;
   assign by_next   = take ? dy_ff : by_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dvalid_ff <= 1'b0;
         have_ff   <= 1'b0;
      end else begin
         dvalid_ff <= dvalid_in;
         have_ff   <= (state_ff == S_BMU) && !finish && (have_ff || take);
      end
   end

   always_ff @(posedge clock) begin
      best_ff <= best_next;
      bx_ff   <= bx_next;
      by_ff   <= by_next;
   end

   // Drive the result word for one cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= finish;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_word_ff.bmu_x         <= COORD_BITS'(bx_next);
         rsp_word_ff.bmu_y         <= COORD_BITS'(by_next);
         rsp_word_ff.best_distance <= best_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   `SBMU_ASSERT_NEXT(a_rsp_one_cycle, clock, reset, rsp_valid, !rsp_valid)
   `SBMU_ASSERT_NOW(a_rsp_when_idle, clock, reset, rsp_valid, !busy)
   `SBMU_ASSERT_NOW(a_no_rsp_in_clear, clock, reset, state_ff == S_CLEAR, !rsp_valid)

endmodule

[sim/bmu_search_checker.sv]
// Watches the request, result and register channels, predicts best-matching nodes and compares
`timescale 1ns / 1ps
module bmu_search_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               busy,
   input  sbmu_pkg::req_word_type             req_word,
   input  logic                               rsp_valid,
   input  sbmu_pkg::rsp_word_type             rsp_word,
   input  logic                               csr_we,
   input  logic [sbmu_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [sbmu_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   output int                                 failures,
   output int                                 pending
);
   import sbmu_pkg::*;

   localparam int MAP_X = 16;
   localparam int MAP_Y = 16;
   localparam int DIMS  = 64;
   localparam int NODES = MAP_X * MAP_Y;
   localparam longint ACC_MAX = 64'sd137438953471;
   localparam longint ACC_MIN = -ACC_MAX - 1;

   logic signed [VALUE_BITS-1:0] weights [NODES*DIMS];
   logic [NORM_BITS-1:0]         node_norm [NODES];
   longint                       dot_acc [NODES];
   logic [4:0]                   width_reg, height_reg;
   logic [6:0]                   dims_reg;
   rsp_word_type                 expected_bmus [$];

   assign pending = expected_bmus.size();

   // register value 0 acts as 1, anything above the maximum as the maximum
   function automatic int clamp_reg(int raw, int top);
      if (raw == 0) return 1;
      return (raw > top) ? top : raw;
   endfunction

   // apply one request word to the predicted state; queue a result if one is due
   function automatic void predict_word(req_word_type w);
      int     wd, ht, dm, x, y, idx, bx, by;
      longint v, old, s, node_dist, best;
      logic [NORM_BITS-1:0] nn;
      rsp_word_type r;
      wd = clamp_reg(int'(width_reg), MAP_X);
      ht = clamp_reg(int'(height_reg), MAP_Y);
      dm = clamp_reg(int'(dims_reg), DIMS);
      v  = w.value;
      if (w.func == FUNC_WEIGHT) begin
         if (w.node_index < wd * ht && w.dim_index < dm) begin
            idx = w.node_index * DIMS + w.dim_index;
            old = weights[idx];
            nn  = NORM_BITS'(node_norm[w.node_index] + v * v - old * old);
            node_norm[w.node_index] = nn;
            weights[idx] = w.value;
         end
         return;
      end
      if (w.dim_index < dm) begin
         for (int n = 0; n < NODES; n++) begin
            s = dot_acc[n] + v * longint'(weights[n * DIMS + w.dim_index]);
            if (s > ACC_MAX) s = ACC_MAX;
            if (s < ACC_MIN) s = ACC_MIN;
            dot_acc[n] = s;
         end
      end
      if (!w.last_element) return;
      // row-major search, strict less-than keeps the earlier node on a tie
      best = 0; bx = 0; by = 0;
      for (y = 0; y < ht; y++) begin
         for (x = 0; x < wd; x++) begin
            idx  = y * wd + x;
            node_dist = longint'(w.vector_norm) + longint'(node_norm[idx])
                      - 2 * dot_acc[idx];
            if (node_dist < 0) node_dist = 0;
            if ((x == 0 && y == 0) || node_dist < best) begin
               best = node_dist; bx = x; by = y;
            end
         end
      end
      r.bmu_x = COORD_BITS'(bx);
      r.bmu_y = COORD_BITS'(by);
      r.best_distance = DIST_BITS'(best);
      expected_bmus.push_back(r);
      foreach (dot_acc[n]) dot_acc[n] = 0;
   endfunction

   always @(posedge clock) begin
      rsp_word_type e;
      if (reset) begin
         foreach (weights[i]) weights[i] = '0;
         foreach (node_norm[i]) node_norm[i] = '0;
         foreach (dot_acc[i]) dot_acc[i] = 0;
         width_reg  = 5'd16;
         height_reg = 5'd16;
         dims_reg   = 7'd64;
         expected_bmus.delete();
         failures   = 0;
      end else begin
         // compare the result word with the oldest prediction
         if (rsp_valid) begin
            if (expected_bmus.size() == 0) begin
               $display("%0t: unexpected result word: expected none, actual x=%0d y=%0d d=%0d",
                        $time, rsp_word.bmu_x, rsp_word.bmu_y, rsp_word.best_distance);
               failures++;
            end else begin
               e = expected_bmus.pop_front();
               if (rsp_word.bmu_x !== e.bmu_x) begin
                  $display("%0t: bmu_x mismatch: expected %0d, actual %0d",
                           $time, e.bmu_x, rsp_word.bmu_x);
                  failures++;
               end
               if (rsp_word.bmu_y !== e.bmu_y) begin
                  $display("%0t: bmu_y mismatch: expected %0d, actual %0d",
                           $time, e.bmu_y, rsp_word.bmu_y);
                  failures++;
               end
               if (rsp_word.best_distance !== e.best_distance) begin
                  $display("%0t: best_distance mismatch: expected %0d, actual %0d",
                           $time, e.best_distance, rsp_word.best_distance);
                  failures++;
               end
            end
         end
         if (start && !busy) predict_word(req_word);
         if (csr_we) begin
            case (csr_index)
               CSR_MAP_WIDTH:  width_reg  = csr_wdata[4:0];
               CSR_MAP_HEIGHT: height_reg = csr_wdata[4:0];
               CSR_DIMENSIONS: dims_reg   = csr_wdata;
               default: ;
            endcase
         end
      end
   end

endmodule

[sim/tb_som_best_matching_unit_sparse.sv]
// Stimulus, clock, reset and verdict for the sparse best-matching-unit search
`timescale 1ns / 1ps
module tb_som_best_matching_unit_sparse;
   import sbmu_pkg::*;

   localparam int     ITEM_TARGET = 1800;
   localparam int     DRAIN_CYCLES = 700;
   localparam longint CYCLE_LIMIT = 6000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_word_type req_word = '0;
   logic rsp_valid;
   rsp_word_type rsp_word;
   logic csr_we = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;
   int     failures, pending;
   int     words_sent = 0;
   bit     gaps_on = 1'b1;
   int     cur_w = 16, cur_h = 16, cur_d = 64;
   longint cycles = 0;

   always #6 clock = ~clock;

   som_best_matching_unit_sparse i_dut (
      .clock, .reset, .start, .busy, .req_word, .rsp_valid, .rsp_word,
      .csr_we, .csr_index, .csr_wdata
   );

   bmu_search_checker i_checker (
      .clock, .reset, .start, .busy, .req_word, .rsp_valid, .rsp_word,
      .csr_we, .csr_index, .csr_wdata, .failures, .pending
   );

   // give up on a hung run
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // hand one request word over; entered and left at a falling edge
   task automatic send_word(req_word_type w);
      if (gaps_on && $urandom_range(0, 7) == 0) begin
         start = 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      start = 1'b1;
      req_word = w;
      while (busy) @(negedge clock);
      @(negedge clock);
      words_sent++;
   endtask

   task automatic write_weight(int node, int dim, int val);
      req_word_type w;
      w = '0;
      w.func = FUNC_WEIGHT;
      w.node_index = NODE_IDX_BITS'(node);
      w.dim_index = DIM_BITS'(dim);
      w.value = VALUE_BITS'(val);
      w.vector_norm = NORM_BITS'({$urandom, $urandom});
      w.last_element = 1'($urandom_range(0, 1));
      send_word(w);
   endtask

   task automatic feed_element(int dim, int val, logic [NORM_BITS-1:0] vnorm, bit last);
      req_word_type w;
      w = '0;
      w.func = FUNC_FEATURE;
      w.node_index = NODE_IDX_BITS'($urandom);
      w.dim_index = DIM_BITS'(dim);
      w.value = VALUE_BITS'(val);
      w.vector_norm = vnorm;
      w.last_element = last;
      send_word(w);
   endtask

   // drain, let the block settle, then change one register
   task automatic write_reg(logic [CSR_IDX_BITS-1:0] idx, int val);
      start = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = CSR_DATA_BITS'(val);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic set_map(int w, int h, int d);
      write_reg(CSR_MAP_WIDTH, w);
      write_reg(CSR_MAP_HEIGHT, h);
      write_reg(CSR_DIMENSIONS, d);
      cur_w = (w == 0) ? 1 : ((w > 16) ? 16 : w);
      cur_h = (h == 0) ? 1 : ((h > 16) ? 16 : h);
      cur_d = (d == 0) ? 1 : ((d > 64) ? 64 : d);
   endtask

   function automatic int rand_value();
      case ($urandom_range(0, 5))
         0: return -32768;
         1: return 32767;
         default: return $urandom_range(0, 65535) - 32768;
      endcase
   endfunction

   // one random sparse vector, mostly in range
   task automatic random_vector();
      int n;
      logic [NORM_BITS-1:0] vn;
      n  = $urandom_range(1, 8);
      vn = ($urandom_range(0, 3) == 0) ? NORM_BITS'({$urandom, $urandom})
                                       : NORM_BITS'($urandom_range(0, 1 << 30));
      for (int i = 0; i < n; i++) begin
         feed_element(($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                                  : $urandom_range(0, cur_d - 1),
                      ($urandom_range(0, 15) == 0) ? 0 : rand_value(), vn, i == n - 1);
      end
   endtask

   // drive node 0 dimension 0 hard so its dot product saturates both ways
   task automatic saturate_vectors();
      write_weight(0, 0, -32768);
      for (int i = 0; i < 140; i++) begin
         feed_element(0, -32768, NORM_BITS'({$urandom, $urandom}), i == 139);
      end
      for (int i = 0; i < 140; i++) feed_element(0, 32767, '1, i == 139);
   endtask

   initial begin
      int phase_start;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extremes, each operation, every special case
      write_weight(0, 0, 32767);
      write_weight(255, 63, -32768);
      write_weight(17, 5, -32768);
      write_weight(17, 5, 1234);
      write_weight(3, 63, 32767);
      feed_element(0, -32768, '0, 1'b0);
      feed_element(5, 32767, '0, 1'b0);
      feed_element(63, -1, '1, 1'b1);
      feed_element(0, 0, '0, 1'b1);
      feed_element(0, 0, 37'd1 << 36, 1'b1);
      set_map(4, 3, 8);
      write_weight(12, 0, 100);
      write_weight(2, 8, 100);
      write_weight(11, 7, -5);
      feed_element(8, 32767, 37'd5, 1'b0);
      feed_element(63, 32767, 37'd5, 1'b1);
      feed_element(7, 2, 37'd0, 1'b1);
      set_map(0, 0, 0);
      write_weight(0, 0, -32768);
      write_weight(1, 0, 77);
      feed_element(0, 32767, '0, 1'b1);
      feed_element(1, -32768, 37'd1000, 1'b1);
      set_map(31, 31, 127);
      feed_element(0, 0, 37'd0, 1'b1);

      // random phases across several map shapes, ending with no gaps
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: set_map(16, 16, 64);
            1: set_map(1, 1, 1);
            2: set_map($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 64));
            3: set_map(2, 16, 3);
            4: set_map($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 127));
            default: set_map(16, 16, 64);
         endcase
         gaps_on = (phase != 5);
         phase_start = words_sent;
         if (phase == 3) saturate_vectors();
         while (words_sent - phase_start < ITEM_TARGET / 6) begin
            if ($urandom_range(0, 2) == 0) begin
               write_weight(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                        : $urandom_range(0, cur_w * cur_h - 1),
                            ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                                        : $urandom_range(0, cur_d - 1),
                            rand_value());
            end else begin
               random_vector();
            end
         end
      end

      start = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
